FILE: src/mmsl_pkg.sv
// Package with shared constants, types and arithmetic helpers of the minmod slope limiter.
`default_nettype none
package mmsl_pkg;

   localparam int MAX_CELLS_DEF = 4096;

   // Field widths
   localparam int VAL_W  = 32;
   localparam int GAP_W  = 31;
   localparam int IDX_W  = 13;
   localparam int GAIN_W = 16;
   localparam int MODE_W = 2;
   localparam int FRAC_W = 16;
   localparam int GSH    = 14;

   // Serial divider: dividend magnitude is |diff| << 16, up to 49 bits
   localparam int DIV_BITS = VAL_W + 1 + FRAC_W;
   localparam int DCNT_W   = $clog2(DIV_BITS);

   // Stream packing
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 48;

   // Configuration register indexes
   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_GAIN  = 2'd1;
   localparam logic [1:0] REG_THREE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_HALF   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET  = 2'd1;
   localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd16384;

   typedef logic signed [VAL_W-1:0] slope_type;

   // Signed saturation of a magnitude with a sign
   function automatic slope_type sat_mag(input logic neg, input logic [DIV_BITS-1:0] m);
      slope_type r;
      if (neg) begin
         if (m > DIV_BITS'(64'h8000_0000)) r = slope_type'(32'h8000_0000);
         else r = slope_type'(-m[VAL_W-1:0]);
      end else begin
         if (m > DIV_BITS'(64'h7FFF_FFFF)) r = slope_type'(32'h7FFF_FFFF);
         else r = slope_type'(m[VAL_W-1:0]);
      end
      return r;
   endfunction

   // Two-way minmod
   function automatic slope_type minmod2(input slope_type a, input slope_type b);
      slope_type r;
      if (a > 0 && b > 0) r = (a < b) ? a : b;
      else if (a < 0 && b < 0) r = (a > b) ? a : b;
      else r = '0;
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/minmod_slope_limiter_radial.sv
// Top level: streaming minmod slope limiter with a bit-serial shared divider.
// Cells 0 and 1 are taken in and give no slope. An interior cell runs two quotients, each a
// setup step and then the one-bit-per-cycle divider, the gain products in three-way mode, the
// minmod step and one emit per slope (1 to 3). One cell at a time: the next cell is accepted
// only after the last slope of the current one is emitted, so output stalls also hold the input.
// Reset: synchronous, active high; clears the stream state and loads mode 1, gain 1.0,
// two-way minmod. No clearing pass.
`default_nettype none
module minmod_slope_limiter_radial #(
   parameter int MAX_CELLS = mmsl_pkg::MAX_CELLS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // cell_value[31:0], old_slope[63:32], centre_gap[94:64], right_half_gap[125:95],
   // left_half_gap[156:126], zero fill
   input  wire logic [mmsl_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tlast,   // is_last
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // cell_index[12:0], limited_slope[44:13], zero fill
   output logic [mmsl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,   // run_end
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_we,
   input  wire logic [1:0]                      csr_addr,
   input  wire logic [mmsl_pkg::GAIN_W-1:0]     csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_CELLS + 2);
   localparam int VAL_W  = mmsl_pkg::VAL_W;
   localparam int GAP_W  = mmsl_pkg::GAP_W;
   localparam int DB     = mmsl_pkg::DIV_BITS;
   localparam int IDX_W  = mmsl_pkg::IDX_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DSET = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_NS   = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   localparam logic [1:0] E_EDGE  = 2'd0;
   localparam logic [1:0] E_INNER = 2'd1;
   localparam logic [1:0] E_GHOST = 2'd2;

   // configuration
   logic [mmsl_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [mmsl_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic                        three_ff, three_in;

   // control
   logic [2:0]       state_ff, state_in;
   logic             phase_ff, phase_in;
   logic [1:0]       mul_cnt_ff, mul_cnt_in;
   logic [1:0]       emit_sel_ff, emit_sel_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // stream state
   mmsl_pkg::slope_type vb1_ff, vb1_in, vb2_ff, vb2_in, pos_ff, pos_in, ledge_ff, ledge_in;
   logic [GAP_W-1:0]    pcg_ff, pcg_in, prh_ff, prh_in, plh_ff, plh_in;

   // current cell
   mmsl_pkg::slope_type cu_ff, cu_in, cos_ff, cos_in;
   logic [GAP_W-1:0]    ccg_ff, ccg_in, crh_ff, crh_in, clh_ff, clh_in;
   logic                clast_ff, clast_in;

   // divider
   logic [VAL_W-1:0]                 rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DB-1:0]                    quo_ff, quo_in;
   logic                             dneg_ff, dneg_in;
   logic [mmsl_pkg::DCNT_W-1:0]      dcnt_ff, dcnt_in;

   // quotients, product, new slope
   mmsl_pkg::slope_type sl_ff, sl_in, sr_ff, sr_in, ns_ff, ns_in;
   logic signed [VAL_W+mmsl_pkg::GAIN_W:0] prod_ff, prod_in;

   // output register
   logic                        rv_ff, rv_in, rl_ff, rl_in;
   logic [IDX_W-1:0]            ridx_ff, ridx_in;
   mmsl_pkg::slope_type         rs_ff, rs_in;

   // helpers
   logic                        accept;
   logic                        last_now;
   logic signed [VAL_W:0]       diff;
   logic [VAL_W:0]              dmag;
   logic [VAL_W-1:0]            dsr_raw;
   logic [VAL_W:0]              shifted, trial;
   logic [DB-1:0]               pmag;
   logic [IDX_W+CNT_W-1:0]      idx_ext;
   logic                        rsp_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign last_now   = req_tlast || (count_ff >= CNT_W'(MAX_CELLS + 1));
   assign rsp_free   = !rv_ff || rsp_tready;

   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = rl_ff;
   assign rsp_tdata  = {{(mmsl_pkg::RSP_DATA_W - IDX_W - VAL_W){1'b0}}, rs_ff, ridx_ff};

   // difference and divisor of the division in progress
   always_comb begin
      if (!phase_ff) begin
         diff = {vb1_ff[VAL_W-1], vb1_ff} - {vb2_ff[VAL_W-1], vb2_ff};
         dsr_raw = (mode_ff == mmsl_pkg::MODE_HALF) ? {prh_ff, 1'b0} : {1'b0, pcg_ff};
      end else begin
         diff = {cu_ff[VAL_W-1], cu_ff} - {vb1_ff[VAL_W-1], vb1_ff};
         dsr_raw = (mode_ff == mmsl_pkg::MODE_HALF) ? {plh_ff, 1'b0} : {1'b0, ccg_ff};
      end
      dmag = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
   end

   // one restoring division step
   assign shifted = {rem_ff, quo_ff[DB-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign pmag    = prod_ff[VAL_W+mmsl_pkg::GAIN_W] ? DB'(-prod_ff) : DB'(prod_ff);
   assign idx_ext = {{IDX_W{1'b0}}, count_ff};

   // sequencer
   always_comb begin
      mode_in = mode_ff; gain_in = gain_ff; three_in = three_ff;
      state_in = state_ff; phase_in = phase_ff; mul_cnt_in = mul_cnt_ff;
      emit_sel_in = emit_sel_ff; count_in = count_ff;
      vb1_in = vb1_ff; vb2_in = vb2_ff; pos_in = pos_ff; ledge_in = ledge_ff;
      pcg_in = pcg_ff; prh_in = prh_ff; plh_in = plh_ff;
      cu_in = cu_ff; cos_in = cos_ff; ccg_in = ccg_ff; crh_in = crh_ff; clh_in = clh_ff;
      clast_in = clast_ff;
      rem_in = rem_ff; dsr_in = dsr_ff; quo_in = quo_ff; dneg_in = dneg_ff; dcnt_in = dcnt_ff;
      sl_in = sl_ff; sr_in = sr_ff; ns_in = ns_ff; prod_in = prod_ff;
      rv_in = rv_ff && !rsp_tready; rl_in = rl_ff; ridx_in = ridx_ff; rs_in = rs_ff;

      // configuration writes
      if (csr_we) begin
         unique case (csr_addr)
            mmsl_pkg::REG_MODE:  mode_in  = csr_wdata[mmsl_pkg::MODE_W-1:0];
            mmsl_pkg::REG_GAIN:  gain_in  = csr_wdata;
            mmsl_pkg::REG_THREE: three_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cu_in    = req_tdata[31:0];
               cos_in   = req_tdata[63:32];
               ccg_in   = req_tdata[94:64];
               crh_in   = req_tdata[125:95];
               clh_in   = req_tdata[156:126];
               clast_in = last_now;
               if (count_ff >= CNT_W'(2)) begin
                  phase_in = 1'b0;
                  state_in = S_DSET;
               end else if (last_now) begin
                  count_in = '0;
               end else begin
                  if (count_ff == '0) ledge_in = req_tdata[63:32];
                  vb2_in   = vb1_ff;
                  vb1_in   = req_tdata[31:0];
                  pos_in   = req_tdata[63:32];
                  pcg_in   = req_tdata[94:64];
                  prh_in   = req_tdata[125:95];
                  plh_in   = req_tdata[156:126];
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         S_DSET: begin
            rem_in   = '0;
            quo_in   = {dmag, {mmsl_pkg::FRAC_W{1'b0}}};
            dneg_in  = diff[VAL_W];
            dsr_in   = (dsr_raw == '0) ? VAL_W'(1) : dsr_raw;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!trial[VAL_W]) begin
               rem_in = trial[VAL_W-1:0];
               quo_in = {quo_ff[DB-2:0], 1'b1};
            end else begin
               rem_in = shifted[VAL_W-1:0];
               quo_in = {quo_ff[DB-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + mmsl_pkg::DCNT_W'(1);
            if (dcnt_ff == mmsl_pkg::DCNT_W'(DB - 1)) begin
               if (!phase_ff) begin
                  sl_in    = mmsl_pkg::sat_mag(dneg_ff, quo_in);
                  phase_in = 1'b1;
                  state_in = S_DSET;
               end else begin
                  sr_in      = mmsl_pkg::sat_mag(dneg_ff, quo_in);
                  mul_cnt_in = '0;
                  state_in   = three_ff ? S_MUL : S_NS;
               end
            end
         end
         S_MUL: begin
            // gain product, then truncating scale by 2^-14
            mul_cnt_in = mul_cnt_ff + 2'd1;
            case (mul_cnt_ff)
               2'd0: prod_in = sl_ff * $signed({1'b0, gain_ff});
               2'd1: begin
                  sl_in   = mmsl_pkg::sat_mag(prod_ff[VAL_W+mmsl_pkg::GAIN_W],
                                              DB'(pmag >> mmsl_pkg::GSH));
                  prod_in = sr_ff * $signed({1'b0, gain_ff});
               end
               default: begin
                  sr_in    = mmsl_pkg::sat_mag(prod_ff[VAL_W+mmsl_pkg::GAIN_W],
                                               DB'(pmag >> mmsl_pkg::GSH));
                  state_in = S_NS;
               end
            endcase
         end
         S_NS: begin
            ns_in = three_ff ? mmsl_pkg::minmod2(mmsl_pkg::minmod2(sl_ff, sr_ff), pos_ff)
                             : mmsl_pkg::minmod2(sl_ff, sr_ff);
            emit_sel_in = (count_ff == CNT_W'(2)) ? E_EDGE : E_INNER;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               rv_in = 1'b1;
               unique case (emit_sel_ff)
                  E_EDGE: begin
                     ridx_in = '0;
                     rs_in   = mmsl_pkg::minmod2(ledge_ff, ns_ff);
                     rl_in   = 1'b0;
                     emit_sel_in = E_INNER;
                  end
                  E_INNER: begin
                     ridx_in = IDX_W'(idx_ext - (IDX_W+CNT_W)'(1));
                     rs_in   = ns_ff;
                     rl_in   = 1'b0;
                     emit_sel_in = E_GHOST;
                  end
                  default: begin
                     ridx_in = idx_ext[IDX_W-1:0];
                     rs_in   = mmsl_pkg::minmod2(ns_ff, cos_ff);
                     rl_in   = 1'b1;
                  end
               endcase
               // wrap up the cell after its final slope
               if ((emit_sel_ff == E_INNER && !clast_ff) || emit_sel_ff == E_GHOST) begin
                  state_in = S_IDLE;
                  if (clast_ff) begin
                     count_in = '0;
                  end else begin
                     vb2_in   = vb1_ff;
                     vb1_in   = cu_ff;
                     pos_in   = cos_ff;
                     pcg_in   = ccg_ff;
                     prh_in   = crh_ff;
                     plh_in   = clh_ff;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mmsl_pkg::MODE_RESET;
         gain_ff <= mmsl_pkg::GAIN_RESET;
         three_ff <= 1'b0;
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
         mul_cnt_ff <= '0;
         emit_sel_ff <= E_EDGE;
         count_ff <= '0;
         vb1_ff <= '0; vb2_ff <= '0; pos_ff <= '0; ledge_ff <= '0;
         pcg_ff <= '0; prh_ff <= '0; plh_ff <= '0;
         dcnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         gain_ff <= gain_in;
         three_ff <= three_in;
         state_ff <= state_in;
         phase_ff <= phase_in;
         mul_cnt_ff <= mul_cnt_in;
         emit_sel_ff <= emit_sel_in;
         count_ff <= count_in;
         vb1_ff <= vb1_in; vb2_ff <= vb2_in; pos_ff <= pos_in; ledge_ff <= ledge_in;
         pcg_ff <= pcg_in; prh_ff <= prh_in; plh_ff <= plh_in;
         dcnt_ff <= dcnt_in;
         rv_ff <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cu_ff <= cu_in; cos_ff <= cos_in; ccg_ff <= ccg_in; crh_ff <= crh_in; clh_ff <= clh_in;
      clast_ff <= clast_in;
      rem_ff <= rem_in; dsr_ff <= dsr_in; quo_ff <= quo_in; dneg_ff <= dneg_in;
      sl_ff <= sl_in; sr_ff <= sr_in; ns_ff <= ns_in; prod_ff <= prod_in;
      rl_ff <= rl_in; ridx_ff <= ridx_in; rs_ff <= rs_in;
   end

   // checks
   a_rem_below_dsr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < dsr_ff)
      else $error("divider remainder not below divisor");
   a_dsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> dsr_ff != '0)
      else $error("zero divisor in divider");
   a_dcnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> dcnt_ff < mmsl_pkg::DCNT_W'(DB))
      else $error("divider step count out of range");
   a_emit_interior: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> count_ff >= CNT_W'(2))
      else $error("slope emitted before two cells seen");

endmodule
`default_nettype wire
